// ----- rtl/modexp_pkg.sv -----
// Shared constants and types for the modular exponentiation block.
// Depends on nothing; used by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

  localparam int unsigned EXP_BITS_DEF = 63;
  localparam int unsigned MOD_BITS_DEF = 31;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // status of the serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ----- rtl/modexp_mulmod.sv -----
// Bit-serial interleaved modular multiplier: prod = (x * y) mod m, x < m.
// Depends on modexp_pkg for the default width and the status struct.
module modexp_mulmod #(
  parameter int unsigned W = modexp_pkg::MOD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          x_i,
  input  logic [W-1:0]          y_i,
  input  logic [W-1:0]          m_i,
  output modexp_pkg::mul_stat_t stat_o,
  output logic [W-1:0]          prod_o
);
  import modexp_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q, y_q, r_q, r_d;
  logic [W:0]    dbl, dbl_red, sum, sum_red, m_ext, addend;

  // one multiplier bit per cycle, MSB first: r = 2r + y_bit * x, kept below m
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    addend  = y_q[W-1] ? {1'b0, x_q} : '0;
    sum     = dbl_red + addend;
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    r_d     = sum_red[W-1:0];
  end

  // sequence the W steps and pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // hold operands and shift the multiplier out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      r_q <= '0;
    end else if (busy_q) begin
      y_q <= y_q << 1;
      r_q <= r_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = r_q;

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Modular exponentiation block: power = base^exponent mod modulus, right-to-left
// square-and-multiply. A command is taken when start_i is high and busy_o is low;
// done_o is high for exactly one cycle with the result on power_o; the strobe cannot
// be stalled. Every modular product runs through one shared bit-serial multiplier
// that works in order: launch, MOD_BITS steps, hand-back. An item costs
// one base reduction plus one product per set exponent bit plus one squaring per
// exponent bit below the highest set bit: (ones + len) products for a nonzero exponent
// of bit length len, one product for a zero exponent, at most 2 * EXP_BITS products.
// The strobe is registered from the multiplier's done pulse for the last product.
// A zero modulus returns 0 without using the multiplier. The modulus register is
// written through the cfg channel, which is always ready; write it only while the
// block is idle.
// Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = modexp_pkg::EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [MOD_BITS-1:0] cfg_modulus_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [MOD_BITS-1:0] base_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                done_o,
  output logic [MOD_BITS-1:0] power_o
);
  import modexp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR
  } state_e;

  state_e              state_q;
  logic [MOD_BITS-1:0] modulus_q;
  logic [MOD_BITS-1:0] acc_q, sq_q, power_q, opx_q, opy_q, prod, one_mod;
  logic [EXP_BITS-1:0] e_q, e_adv;
  logic                go_q, done_q;
  mul_stat_t           mul_stat;

  // modulus register, written by a cfg transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET[MOD_BITS-1:0];
    end else if (cfg_valid_i && cfg_ready_o) begin
      modulus_q <= cfg_modulus_i;
    end
  end

  // 1 mod m: zero for a modulus of one
  assign one_mod = (modulus_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  // a squaring consumes the lowest exponent bit
  assign e_adv   = (state_q == ST_SQR) ? (e_q >> 1) : e_q;

  modexp_mulmod #(
    .W(MOD_BITS)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(go_q),
    .x_i    (opx_q),
    .y_i    (opy_q),
    .m_i    (modulus_q),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  // sequencer: reduce the base, then multiply on set bits and square up to the top set bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
      acc_q   <= '0;
      sq_q    <= '0;
      e_q     <= '0;
      opx_q   <= '0;
      opy_q   <= '0;
      power_q <= '0;
    end else begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            if (modulus_q == '0) begin
              power_q <= '0;
              done_q  <= 1'b1;
            end else begin
              // base mod m computed as (1 mod m) * base
              acc_q   <= one_mod;
              e_q     <= exponent_i;
              opx_q   <= one_mod;
              opy_q   <= base_i;
              go_q    <= 1'b1;
              state_q <= ST_RED;
            end
          end
        end
        ST_RED, ST_SQR: begin
          if (mul_stat.done) begin
            sq_q <= prod;
            e_q  <= e_adv;
            if (e_adv == '0) begin
              power_q <= acc_q;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else if (e_adv[0]) begin
              opx_q   <= acc_q;
              opy_q   <= prod;
              go_q    <= 1'b1;
              state_q <= ST_MUL;
            end else begin
              opx_q   <= prod;
              opy_q   <= prod;
              go_q    <= 1'b1;
              state_q <= ST_SQR;
            end
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            acc_q <= prod;
            if ((e_q >> 1) == '0) begin
              power_q <= prod;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              opx_q   <= sq_q;
              opy_q   <= sq_q;
              go_q    <= 1'b1;
              state_q <= ST_SQR;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign power_o = power_q;

  // result is always reduced below a nonzero modulus
  a_power_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (modulus_q != '0) |-> power_o < modulus_q)
    else $error("power_o not reduced below modulus");

  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted command dropped");

  // the multiplier only runs while the sequencer is working
  a_mul_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.busy || mul_stat.done |-> busy_o)
    else $error("multiplier active while idle");

  // a result strobe never overlaps a running command
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done_o while busy");

endmodule

// ----- tb/modular_exponentiation_tb.sv -----
// Self-checking testbench for modular_exponentiation: directed corner cases, then
// random commands over several modulus settings, checked against an in-bench predictor.
// Depends on modexp_pkg and the modular_exponentiation RTL.
module modular_exponentiation_tb;

  import modexp_pkg::*;

  localparam int unsigned MOD_W = MOD_BITS_DEF;
  localparam int unsigned EXP_W = EXP_BITS_DEF;
  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
  localparam logic [MOD_W-1:0] MOD_AT_RESET = MODULUS_RESET[MOD_W-1:0];
  // allow for the worst-case item in the tail and the limit
  localparam int unsigned TAIL_CYCLES = 4400;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

  typedef struct {
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] exponent;
    logic [MOD_W-1:0] power;
  } power_job_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [MOD_W-1:0] cfg_modulus_i;
  logic             start_i;
  logic             busy_o;
  logic [MOD_W-1:0] base_i;
  logic [EXP_W-1:0] exponent_i;
  logic             done_o;
  logic [MOD_W-1:0] power_o;

  logic [MOD_W-1:0] model_modulus;
  power_job_t       pending_powers[$];
  int unsigned      error_count = 0;
  longint unsigned  cycle_count = 0;

  modular_exponentiation #(
    .EXP_BITS(EXP_W),
    .MOD_BITS(MOD_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_modulus_i(cfg_modulus_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .base_i       (base_i),
    .exponent_i   (exponent_i),
    .done_o       (done_o),
    .power_o      (power_o)
  );

  // clock, period 8
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[modular_exponentiation] ERROR");
      $finish;
    end
  end

  // right-to-left square-and-multiply over the full exponent width
  function automatic logic [MOD_W-1:0] modpow_predict(logic [MOD_W-1:0] m,
                                                      logic [MOD_W-1:0] b,
                                                      logic [EXP_W-1:0] e);
    longint unsigned mm;
    longint unsigned sq;
    longint unsigned acc;
    if (m == '0) return '0;
    mm  = m;
    sq  = b % mm;
    acc = 1 % mm;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  function automatic logic [EXP_W-1:0] random_wide();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[EXP_W-1:0];
  endfunction

  // mostly short exponents to keep the run short, some full width
  function automatic logic [EXP_W-1:0] random_exponent();
    logic [EXP_W-1:0] e;
    int unsigned      len;
    e = random_wide();
    if ($urandom_range(0, 9) < 2) return e;
    len = $urandom_range(1, 24);
    e   = e & EXP_W'((64'd1 << len) - 64'd1);
    if ($urandom_range(0, 1) == 0) e[len-1] = 1'b1;
    return e;
  endfunction

  function automatic logic [MOD_W-1:0] random_base(logic [MOD_W-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return m - MOD_W'(1);
      2: return m;
      3: return MOD_MAX;
      4: return (m > 1) ? MOD_W'($urandom_range(0, m - 1)) : '0;
      default: return MOD_W'($urandom());
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] pick_modulus();
    case ($urandom_range(0, 5))
      0: return MOD_W'(2);
      1: return MOD_MAX;
      2: return MOD_AT_RESET;
      3: return MOD_W'($urandom_range(2, 100));
      default: return MOD_W'($urandom_range(2, 32'h7fff_ffff));
    endcase
  endfunction

  // check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    power_job_t job;
    if (rst_ni && done_o) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result power=%0d expected=none", $time, power_o);
        error_count++;
      end else begin
        job = pending_powers.pop_front();
        if (power_o !== job.power) begin
          $display("%0t: power mismatch (mod=%0d base=%0d exp=%0h) expected=%0d actual=%0d",
                   $time, job.modulus, job.base, job.exponent, job.power, power_o);
          error_count++;
        end
      end
    end
  end

  // write the modulus register; entered and left at a falling edge
  task automatic write_modulus(logic [MOD_W-1:0] value);
    cfg_valid_i   = 1'b1;
    cfg_modulus_i = value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    model_modulus = value;
    @(negedge clk_i);
    cfg_valid_i   = 1'b0;
    cfg_modulus_i = MOD_W'($urandom());
  endtask

  // issue one command and record its expected power; entered and left at a falling edge
  task automatic send_item(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
    power_job_t job;
    start_i    = 1'b1;
    base_i     = b;
    exponent_i = e;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    job.modulus = model_modulus;
    job.base    = b;
    job.exponent = e;
    job.power   = modpow_predict(model_modulus, b, e);
    pending_powers.push_back(job);
    @(negedge clk_i);
    // scramble the fields so a late sample of them shows up
    start_i    = 1'b0;
    base_i     = MOD_W'($urandom());
    exponent_i = random_wide();
  endtask

  // hold until every result is back and the block is idle
  task automatic wait_drained();
    while (pending_powers.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic sender_gap(bit idle_on);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
  endtask

  // commands under the modulus left by reset
  task automatic test_reset_modulus();
    send_item('0, '0);
    send_item('0, EXP_W'(5));
    send_item(MOD_MAX, '0);
    send_item(MOD_MAX, EXP_MAX);
    send_item(MOD_AT_RESET - MOD_W'(1), EXP_W'(2));
    send_item(MOD_W'(2), EXP_W'(MOD_AT_RESET - 2));
    send_item(MOD_W'(12345), EXP_W'(1));
    wait_drained();
  endtask

  // extreme and degenerate modulus values, including one and zero
  task automatic test_modulus_extremes();
    write_modulus(MOD_MAX);
    send_item(MOD_MAX, EXP_W'(7));
    send_item(MOD_MAX - MOD_W'(1), EXP_MAX);
    send_item(MOD_W'(3), EXP_W'(1) << (EXP_W - 1));
    wait_drained();
    write_modulus(MOD_W'(2));
    send_item(MOD_W'(3), '0);
    send_item(MOD_W'(3), EXP_W'(5));
    send_item(MOD_W'(2), EXP_W'(9));
    send_item('0, '0);
    wait_drained();
    write_modulus(MOD_W'(1));
    send_item(MOD_W'(5), '0);
    send_item(MOD_W'(5), EXP_W'(3));
    wait_drained();
    write_modulus('0);
    send_item(MOD_W'(5), '0);
    send_item(MOD_W'(7), EXP_W'(123));
    wait_drained();
    write_modulus(MOD_W'(3));
    send_item(MOD_W'(2), EXP_W'({(EXP_W+1)/2{2'b01}}));
    wait_drained();
  endtask

  // random commands over several modulus settings, with idling and drain pauses
  task automatic test_random_mix(int unsigned phases, int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      write_modulus(pick_modulus());
      for (int n = 0; n < per_phase; n++) begin
        sender_gap(1'b1);
        // now and then let everything drain before the next command
        if ($urandom_range(0, 19) == 0) wait_drained();
        send_item(random_base(model_modulus), random_exponent());
      end
      wait_drained();
    end
  endtask

  // commands issued as fast as the block takes them
  task automatic test_back_to_back(int unsigned count);
    write_modulus(MOD_AT_RESET);
    for (int n = 0; n < count; n++) begin
      send_item(random_base(model_modulus), random_exponent());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_modulus_i = '0;
    start_i       = 1'b0;
    base_i        = '0;
    exponent_i    = '0;
    model_modulus = MOD_AT_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_modulus();
    test_modulus_extremes();
    test_random_mix(6, 42);
    test_back_to_back(20);

    // drain, then watch for stray strobes
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0 && pending_powers.size() == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

endmodule
